@@ src/iocr_pkg.sv @@
// ----------------------------------------------------------------------------
// iocr_pkg: shared types and codes for the in-order completion ring
// Operation codes, result codes, sizing defaults and the result record
// passed from the slot controller to the top level.
// ----------------------------------------------------------------------------
package iocr_pkg;

  localparam int RING_SIZE_DEFAULT = 16;

  // Port widths
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int WORD_W  = 32;
  localparam int CODE_W  = 3;
  localparam int COUNT_W = 5;

  // Operations
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RETIRE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // Result codes
  localparam logic [CODE_W-1:0] RC_OK           = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL         = 3'd1;
  localparam logic [CODE_W-1:0] RC_LIMIT        = 3'd2;
  localparam logic [CODE_W-1:0] RC_EMPTY        = 3'd3;
  localparam logic [CODE_W-1:0] RC_HEAD_PENDING = 3'd4;
  localparam logic [CODE_W-1:0] RC_NOT_INFLIGHT = 3'd5;

  // Registered result of one operation
  typedef struct packed {
    logic               valid;
    logic               pop;
    logic [CODE_W-1:0]  code;
    logic [SLOT_W-1:0]  slot_idx;
    logic [COUNT_W-1:0] occupancy;
    logic [COUNT_W-1:0] inflight;
  } iocr_res_t;

endpackage

@@ src/iocr_ram.sv @@
// ----------------------------------------------------------------------------
// iocr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module iocr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/iocr_ctrl.sv @@
// ----------------------------------------------------------------------------
// iocr_ctrl: slot controller of the in-order completion ring
// Holds head/tail pointers, fill and in-flight counters, per-slot flags and
// the in-flight limit; decides each operation and registers its result.
// ----------------------------------------------------------------------------
module iocr_ctrl #(
  parameter int RING_SIZE = iocr_pkg::RING_SIZE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [iocr_pkg::MODE_W-1:0]       mode,
  input  logic [iocr_pkg::SLOT_W-1:0]       slot,
  input  logic                              cfg_we,
  input  logic [iocr_pkg::COUNT_W-1:0]      cfg_data,
  output logic                              tag_we,
  output logic [$clog2(RING_SIZE)-1:0]      tag_waddr,
  output logic                              stat_we,
  output logic [$clog2(RING_SIZE)-1:0]      stat_waddr,
  output logic [$clog2(RING_SIZE)-1:0]      rd_addr,
  output iocr_pkg::iocr_res_t               res
);
  import iocr_pkg::*;

  localparam int AW = $clog2(RING_SIZE);
  localparam int CW = $clog2(RING_SIZE + 1);
  localparam int LIMIT_RESET = (16 < RING_SIZE) ? 16 : RING_SIZE;

  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        busy_cnt;
  logic [CW-1:0]        limit;
  logic [RING_SIZE-1:0] done_flags;
  logic [RING_SIZE-1:0] pend_flags;

  logic [AW-1:0] slot_sel;
  logic          alloc_ok;
  logic          finish_ok;
  logic          retire_ok;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] busy_next;
  logic [CODE_W-1:0] code_next;
  logic [AW-1:0]     idx_next;

  assign slot_sel = AW'(slot);

  always_comb begin
    alloc_ok  = 1'b0;
    finish_ok = 1'b0;
    retire_ok = 1'b0;
    code_next = RC_OK;
    idx_next  = head;
    fill_next = fill;
    busy_next = busy_cnt;
    unique case (mode)
      MODE_ALLOC: begin
        idx_next = tail;
        if (fill == CW'(RING_SIZE)) begin
          code_next = RC_FULL;
        end else if (busy_cnt >= limit) begin
          code_next = RC_LIMIT;
        end else begin
          alloc_ok  = 1'b1;
          fill_next = fill + 1'b1;
          busy_next = busy_cnt + 1'b1;
        end
      end
      MODE_FINISH: begin
        idx_next = slot_sel;
        if (!pend_flags[slot_sel]) begin
          code_next = RC_NOT_INFLIGHT;
        end else begin
          finish_ok = 1'b1;
          if (busy_cnt != '0) begin
            busy_next = busy_cnt - 1'b1;
          end
        end
      end
      MODE_RETIRE: begin
        if (fill == '0) begin
          code_next = RC_EMPTY;
        end else if (!done_flags[head]) begin
          code_next = RC_HEAD_PENDING;
        end else begin
          retire_ok = 1'b1;
          fill_next = fill - 1'b1;
        end
      end
      default: begin
        code_next = RC_OK;
      end
    endcase
  end

  assign tag_we     = accept && alloc_ok;
  assign tag_waddr  = tail;
  assign stat_we    = accept && finish_ok;
  assign stat_waddr = slot_sel;
  assign rd_addr    = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      busy_cnt   <= '0;
      limit      <= CW'(LIMIT_RESET);
      done_flags <= '0;
      pend_flags <= '0;
      res.valid  <= 1'b0;
      res.pop    <= 1'b0;
    end else begin
      // clamp limit writes to the ring size
      if (cfg_we) begin
        if (32'(cfg_data) > RING_SIZE) begin
          limit <= CW'(RING_SIZE);
        end else begin
          limit <= CW'(cfg_data);
        end
      end
      res.valid <= accept && (mode != MODE_NONE);
      res.pop   <= accept && retire_ok;
      if (accept) begin
        fill     <= fill_next;
        busy_cnt <= busy_next;
        // hold the result payload for the word just taken
        res.code      <= code_next;
        res.slot_idx  <= SLOT_W'(idx_next);
        res.occupancy <= COUNT_W'(fill_next);
        res.inflight  <= COUNT_W'(busy_next);
        if (alloc_ok) begin
          done_flags[tail] <= 1'b0;
          pend_flags[tail] <= 1'b1;
          tail             <= tail + 1'b1;
        end
        if (finish_ok) begin
          done_flags[slot_sel] <= 1'b1;
          pend_flags[slot_sel] <= 1'b0;
        end
        if (retire_ok) begin
          done_flags[head] <= 1'b0;
          head             <= head + 1'b1;
        end
      end
    end
  end

endmodule

@@ src/in_order_completion_ring.sv @@
// ----------------------------------------------------------------------------
// in_order_completion_ring: in-order completion buffer
// Hands out ring slots in order, lets them finish in any order and retires
// them in order from the head.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive mode/slot/request_tag/done_status with start high;
//   the word is taken at any edge where start is high and busy is low. busy
//   stays low, so one command is taken every cycle.
//   Modes: allocate claims the tail slot for request_tag, finish stores
//   done_status into an in-flight slot, retire pops the head slot once done.
//   The unused mode is taken and produces no result.
//   Result channel: result_valid pulses for one cycle, in the cycle after
//   the command was taken, carrying code, slot, counts and, on a successful
//   retire, the retired tag and status (zero otherwise). Tag and status come
//   from the registered read of the tag and status RAMs at the head pointer.
//   The receiver cannot stall; every result must be taken when shown.
//   Config channel: cfg_valid/cfg_ready write the in-flight limit from
//   cfg_data; cfg_ready is always high and values above the ring size clamp.
//   Reset (rst, synchronous): empties the ring, clears all flags and counters
//   and sets the limit to the smaller of 16 and the ring size.
// ----------------------------------------------------------------------------
module in_order_completion_ring #(
  parameter int RING_SIZE = iocr_pkg::RING_SIZE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // command
  input  logic                               start,
  output logic                               busy,
  input  logic [iocr_pkg::MODE_W-1:0]        mode,
  input  logic [iocr_pkg::SLOT_W-1:0]        slot,
  input  logic [iocr_pkg::WORD_W-1:0]        request_tag,
  input  logic signed [iocr_pkg::WORD_W-1:0] done_status,
  // config
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iocr_pkg::COUNT_W-1:0]       cfg_data,
  // result
  output logic                               result_valid,
  output logic [iocr_pkg::CODE_W-1:0]        result_code,
  output logic [iocr_pkg::SLOT_W-1:0]        slot_index,
  output logic [iocr_pkg::WORD_W-1:0]        retired_tag,
  output logic signed [iocr_pkg::WORD_W-1:0] retired_status,
  output logic [iocr_pkg::COUNT_W-1:0]       occupancy,
  output logic [iocr_pkg::COUNT_W-1:0]       inflight_count
);
  import iocr_pkg::*;

  localparam int AW = $clog2(RING_SIZE);

  logic          accept;
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic          stat_we;
  logic [AW-1:0] stat_waddr;
  logic [AW-1:0] rd_addr;
  logic [WORD_W-1:0] tag_q;
  logic [WORD_W-1:0] stat_q;
  iocr_res_t     res;

  // every cycle takes a command; config is always taken
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  iocr_ctrl #(.RING_SIZE(RING_SIZE)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .slot       (slot),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .tag_we     (tag_we),
    .tag_waddr  (tag_waddr),
    .stat_we    (stat_we),
    .stat_waddr (stat_waddr),
    .rd_addr    (rd_addr),
    .res        (res)
  );

  // tag written at the tail on allocate, read at the head
  iocr_ram #(.WIDTH(WORD_W), .DEPTH(RING_SIZE)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (request_tag),
    .raddr (rd_addr),
    .rdata (tag_q)
  );

  // status written at the finished slot, read at the head
  iocr_ram #(.WIDTH(WORD_W), .DEPTH(RING_SIZE)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (done_status),
    .raddr (rd_addr),
    .rdata (stat_q)
  );

  // present the result; drop tag and status unless the head was popped
  assign result_valid   = res.valid;
  assign result_code    = res.code;
  assign slot_index     = res.slot_idx;
  assign occupancy      = res.occupancy;
  assign inflight_count = res.inflight;
  assign retired_tag    = res.pop ? tag_q : '0;
  assign retired_status = res.pop ? signed'(stat_q) : '0;

endmodule

@@ src/iocr_checker.sv @@
// ----------------------------------------------------------------------------
// iocr_checker: port-level checks for the in-order completion ring
// Watches the command and result channels over time.
// ----------------------------------------------------------------------------
module iocr_checker #(
  parameter int RING_SIZE = iocr_pkg::RING_SIZE_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [iocr_pkg::MODE_W-1:0]        mode,
  input logic                               result_valid,
  input logic [iocr_pkg::CODE_W-1:0]        result_code,
  input logic [iocr_pkg::WORD_W-1:0]        retired_tag,
  input logic signed [iocr_pkg::WORD_W-1:0] retired_status,
  input logic [iocr_pkg::COUNT_W-1:0]       occupancy,
  input logic [iocr_pkg::COUNT_W-1:0]       inflight_count
);
  import iocr_pkg::*;

  // a taken command with a real mode yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode != MODE_NONE) |=> result_valid)
    else $error("result missing after command");

  // no result without a command in the previous cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && mode != MODE_NONE))
    else $error("result without command");

  // tag and status are zero unless an operation succeeded
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_code != RC_OK) |-> (retired_tag == '0 && retired_status == '0))
    else $error("refused result carries tag or status");

  // in-flight requests all sit inside the ring; checked for ring sizes up to 16
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (RING_SIZE > 16 || inflight_count <= occupancy))
    else $error("inflight count above occupancy");

endmodule

bind in_order_completion_ring iocr_checker #(.RING_SIZE(RING_SIZE)) u_iocr_checker (.*);
